FILE: rtl/core/afm_pkg.sv
`default_nettype none

package afm_pkg;

   // Sine quarter-wave table size and the widths that follow from it
   localparam int SINE_N  = 256;
   localparam int SINE_AW = $clog2(SINE_N);
   localparam int IDX_W   = SINE_AW + 2;
   // quotient width of the phase divider: 4*amplitude < 1024, sine index < 4N
   localparam int QW      = (IDX_W > 10) ? IDX_W : 10;
   localparam int MW      = QW + 1;
   localparam int XW      = 16 + MW;
   localparam int LW      = QW + 3;

   // Flicker type codes
   localparam logic [2:0] FLICK_NONE     = 3'd0;
   localparam logic [2:0] FLICK_TRIANGLE = 3'd1;
   localparam logic [2:0] FLICK_SAW_DOWN = 3'd2;
   localparam logic [2:0] FLICK_SAW_UP   = 3'd3;
   localparam logic [2:0] FLICK_SQUARE   = 3'd4;
   localparam logic [2:0] FLICK_SINE     = 3'd5;

   // Register indexes
   localparam logic [2:0] CSR_TYPE       = 3'd0;
   localparam logic [2:0] CSR_PERIOD     = 3'd1;
   localparam logic [2:0] CSR_RANDOM_PCT = 3'd2;
   localparam logic [2:0] CSR_AMPLITUDE  = 3'd3;

   // m / 12700 = ((m >> 2) * ceil(2^41 / 3175)) >> 41, exact for m < 2^31
   localparam int          STRETCH_QW    = 17;
   localparam logic [29:0] STRETCH_RECIP = 30'd692605750;
   localparam int          STRETCH_SHIFT = 41;
   localparam logic [15:0] PERIOD_MAX  = 16'hFFFF;
   localparam int          LEVEL_MID   = 128;
   localparam int          LEVEL_MAX   = 255;
   localparam int          SINE_ONE    = 32768;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic [15:0]       tick;
      logic signed [7:0] flick_offset;
      logic [7:0]        alpha_primary;
      logic [7:0]        alpha_secondary;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] alpha_primary_out;
      logic [7:0] alpha_secondary_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [15:0] value;
   } csr_payload_type;

   typedef logic [15:0] sine_rom_type [0:SINE_N];

   // sin(pi/2 * i / N) in Q15, Taylor series in Q30
   function automatic logic [15:0] quarter_sine(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_N;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      r = (sum + 64'd16384) >> 15;
      if (r > 64'(SINE_ONE)) begin
         r = 64'(SINE_ONE);
      end
      return r[15:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i <= SINE_N; i++) begin
         rom[i] = quarter_sine(i);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: rtl/core/afm_if.sv
`default_nettype none

interface afm_req_if import afm_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface afm_rsp_if import afm_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface afm_csr_if import afm_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/afm_out_buf.sv
`default_nettype none

module afm_out_buf import afm_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire rsp_payload_type in_data,
   output logic                 skid_full,
   afm_rsp_if.source            rsp
);

   logic            out_v_ff;
   logic            out_v_in;
   rsp_payload_type out_d_ff;
   rsp_payload_type out_d_in;
   logic            sk_v_ff;
   logic            sk_v_in;
   rsp_payload_type sk_d_ff;
   rsp_payload_type sk_d_in;
   logic            take;

   assign take = out_v_ff & rsp.ready;

   // Refill the output register from the skid stage first, then from the pipe
   always_comb begin
      out_v_in = out_v_ff;
      out_d_in = out_d_ff;
      sk_v_in  = sk_v_ff;
      sk_d_in  = sk_d_ff;
      if (sk_v_ff) begin
         if (take) begin
            out_d_in = sk_d_ff;
            sk_v_in  = 1'b0;
         end
      end else if (take || !out_v_ff) begin
         out_v_in = in_valid;
         out_d_in = in_data;
      end else if (in_valid) begin
         sk_v_in = 1'b1;
         sk_d_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
      out_d_ff <= out_d_in;
      sk_d_ff  <= sk_d_in;
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_d_ff;
   assign skid_full = sk_v_ff;

endmodule

`default_nettype wire

FILE: rtl/core/alpha_flicker_modulator_core.sv
`default_nettype none

// Channel   Direction  Payload
// req_chan  in         tick, flick_offset, alpha_primary, alpha_secondary
// rsp_chan  out        alpha_primary_out, alpha_secondary_out
// csr_chan  in         register index, write data (always ready)
//
// One transaction enters per cycle while req_chan.ready is high (skid stage not
// full). With the default 256-entry sine table, one reciprocal multiply
// divides by 12700, 16 compare-subtract stages form the tick modulo the period
// and 10 form the phase quotient.
// Reset clears the configuration registers and all stage valid bits.
// A stalled result moves into a skid stage; the pipe holds only once that is full.

module alpha_flicker_modulator_core import afm_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   afm_req_if.sink   req_chan,
   afm_rsp_if.source rsp_chan,
   afm_csr_if.sink   csr_chan
);

   localparam int S_MUL = 1;
   localparam int S_DA0 = 2;
   localparam int S_PER = S_DA0 + 1;
   localparam int S_DB0 = S_PER + 1;
   localparam int S_X   = S_DB0 + 16;
   localparam int S_DC0 = S_X + 1;
   localparam int S_L1  = S_DC0 + QW;
   localparam int S_L2  = S_L1 + 1;
   localparam int NST   = S_L2 + 1;

   typedef struct packed {
      logic [7:0]  ap;
      logic [7:0]  as;
      logic [15:0] tm1;
      logic        neg;
      logic        le;
   } carry_type;

   // Configuration registers
   logic [2:0]  type_ff;
   logic [15:0] period_ff;
   logic [6:0]  pct_ff;
   logic [7:0]  amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= FLICK_NONE;
         period_ff <= '0;
         pct_ff    <= '0;
         amp_ff    <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.data.index)
            CSR_TYPE:       type_ff   <= csr_chan.data.value[2:0];
            CSR_PERIOD:     period_ff <= csr_chan.data.value;
            CSR_RANDOM_PCT: pct_ff    <= csr_chan.data.value[6:0];
            CSR_AMPLITUDE:  amp_ff    <= csr_chan.data.value[7:0];
            default: ;
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   logic en;
   logic skid_full;

   assign en             = !skid_full;
   assign req_chan.ready = en;

   // Valid bits and pass-along fields
   logic [NST-1:0] vld_ff;
   carry_type      carry_ff [NST];
   carry_type      carry_in [NST];
   carry_type      carry_x_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_chan.valid};
      end
   end

   always_comb begin
      carry_in[0].ap  = req_chan.data.alpha_primary;
      carry_in[0].as  = req_chan.data.alpha_secondary;
      carry_in[0].tm1 = req_chan.data.tick - 16'd1;
      carry_in[0].neg = req_chan.data.flick_offset[7];
      carry_in[0].le  = 1'b0;
      for (int k = 1; k < NST; k++) begin
         carry_in[k] = carry_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NST; k++) begin
            carry_ff[k] <= (k == S_X) ? carry_x_in : carry_in[k];
         end
      end
   end

   // Stage 0: magnitude of offset times percentage
   logic [7:0]  off_mag;
   logic [14:0] prod_ff;
   logic [14:0] prod_in;

   assign off_mag = req_chan.data.flick_offset[7] ? 8'(-req_chan.data.flick_offset)
                                                  : 8'(req_chan.data.flick_offset);
   assign prod_in = 15'(off_mag) * 15'(pct_ff);

   // Stage 1: scale by the base period
   logic [30:0] m_ff;
   logic [30:0] m_in;

   assign m_in = 31'(period_ff) * 31'(prod_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         m_ff    <= m_in;
      end
   end

   // Divide by 12700 as a multiply by the reciprocal of 12700/4
   logic [58:0]           qprod;
   logic [STRETCH_QW-1:0] qa_ff;

   assign qprod = 59'(m_ff[30:2]) * 59'(STRETCH_RECIP);

   always_ff @(posedge clock) begin
      if (en) begin
         qa_ff <= qprod[STRETCH_SHIFT +: STRETCH_QW];
      end
   end

   // Stretch the period, clamp to 1..0xFFFF
   logic signed [18:0] stretch;
   logic [15:0]        per_ff;
   logic [15:0]        per_in;

   assign stretch = carry_ff[S_PER-1].neg
                  ? 19'(period_ff) - 19'(qa_ff)
                  : 19'(period_ff) + 19'(qa_ff);

   always_comb begin
      if (stretch <= 19'sd0) begin
         per_in = 16'd1;
      end else if (stretch > 19'(PERIOD_MAX)) begin
         per_in = PERIOD_MAX;
      end else begin
         per_in = stretch[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         per_ff <= per_in;
      end
   end

   // Tick minus one modulo the period
   logic [15:0] remb_ff [16];
   logic [15:0] pb_ff   [16];

   for (genvar b = 0; b < 16; b++) begin : g_divb
      logic [15:0] src;
      logic [15:0] pd;
      logic [31:0] dv;
      logic        ge;
      logic [15:0] rem_in;
      if (b == 0) begin : g_first
         assign src = carry_ff[S_PER].tm1;
         assign pd  = per_ff;
      end else begin : g_next
         assign src = remb_ff[b-1];
         assign pd  = pb_ff[b-1];
      end
      assign dv     = 32'(pd) << (15 - b);
      assign ge     = 32'(src) >= dv;
      assign rem_in = ge ? src - dv[15:0] : src;
      always_ff @(posedge clock) begin
         if (en) begin
            remb_ff[b] <= rem_in;
            pb_ff[b]   <= pd;
         end
      end
   end

   // Phase numerator: pos times the slope factor of the waveform
   logic [15:0]   pos;
   logic [15:0]   px_pd;
   logic [MW-1:0] mult;
   logic [XW-1:0] x_ff;
   logic [XW-1:0] x_in;
   logic [15:0]   px_ff;

   assign pos   = remb_ff[15];
   assign px_pd = pb_ff[15];

   always_comb begin
      unique case (type_ff)
         FLICK_TRIANGLE:            mult = MW'({amp_ff, 2'b00});
         FLICK_SAW_DOWN,
         FLICK_SAW_UP:              mult = MW'({amp_ff, 1'b0});
         FLICK_SINE:                mult = MW'(4 * SINE_N);
         default:                   mult = '0;
      endcase
      carry_x_in    = carry_in[S_X];
      carry_x_in.le = {pos, 1'b0} <= {1'b0, px_pd};
   end

   assign x_in = XW'(pos) * XW'(mult);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         px_ff <= px_pd;
      end
   end

   // Phase quotient: numerator over the period
   logic [XW-1:0] remc_ff [QW];
   logic [QW-1:0] qc_ff   [QW];
   logic [15:0]   pc_ff   [QW];

   for (genvar c = 0; c < QW; c++) begin : g_divc
      logic [XW-1:0] src;
      logic [QW-1:0] qsrc;
      logic [15:0]   pd;
      logic [XW-1:0] dv;
      logic          ge;
      if (c == 0) begin : g_first
         assign src  = x_ff;
         assign qsrc = '0;
         assign pd   = px_ff;
      end else begin : g_next
         assign src  = remc_ff[c-1];
         assign qsrc = qc_ff[c-1];
         assign pd   = pc_ff[c-1];
      end
      assign dv = XW'(pd) << (QW - 1 - c);
      assign ge = src >= dv;
      always_ff @(posedge clock) begin
         if (en) begin
            remc_ff[c] <= ge ? src - dv : src;
            qc_ff[c]   <= (QW == 1) ? QW'(ge) : {qsrc[QW-2:0], ge};
            pc_ff[c]   <= pd;
         end
      end
   end

   // Level stage 1: linear waveforms, sine table fetch
   logic [QW-1:0]        qv;
   logic signed [LW-1:0] q_s;
   logic signed [LW-1:0] amp_s;
   logic signed [LW-1:0] mid_s;
   logic signed [LW-1:0] lin_in;
   logic signed [LW-1:0] lin_ff;
   logic [IDX_W-1:0]     idx;
   logic [1:0]           quad;
   logic [SINE_AW:0]     rix;
   logic [15:0]          smag_ff;
   logic                 sneg_ff;
   logic                 le1;

   assign qv    = qc_ff[QW-1];
   assign q_s   = LW'(qv);
   assign amp_s = LW'(amp_ff);
   assign mid_s = LW'(LEVEL_MID);
   assign le1   = carry_ff[S_L1-1].le;
   assign idx   = qv[IDX_W-1:0];
   assign quad  = idx[IDX_W-1 -: 2];
   assign rix   = quad[0] ? (SINE_AW+1)'(SINE_N) - (SINE_AW+1)'(idx[SINE_AW-1:0])
                          : (SINE_AW+1)'(idx[SINE_AW-1:0]);

   always_comb begin
      unique case (type_ff)
         FLICK_TRIANGLE: lin_in = le1 ? mid_s - amp_s + q_s
                                      : mid_s + LW'(3) * amp_s - q_s;
         FLICK_SAW_DOWN: lin_in = mid_s + amp_s - q_s;
         FLICK_SAW_UP:   lin_in = mid_s - amp_s + q_s;
         FLICK_SQUARE:   lin_in = le1 ? mid_s + amp_s : mid_s - amp_s;
         default:        lin_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_ff  <= lin_in;
         smag_ff <= SINE_ROM[rix];
         sneg_ff <= quad[1];
      end
   end

   // Level stage 2: sine scaling and clamp to 0..255
   logic [23:0]        sprod;
   logic signed [25:0] ssum;
   logic [7:0]         level_in;
   logic [7:0]         level_ff;

   assign sprod = 24'(amp_ff) * 24'(smag_ff);
   assign ssum  = sneg_ff ? 26'(LEVEL_MID * SINE_ONE) - 26'(sprod)
                          : 26'(LEVEL_MID * SINE_ONE) + 26'(sprod);

   always_comb begin
      if (type_ff == FLICK_SINE) begin
         if (ssum < 26'sd0) begin
            level_in = '0;
         end else if ((ssum >>> 15) > 26'(LEVEL_MAX)) begin
            level_in = 8'(LEVEL_MAX);
         end else begin
            level_in = 8'(ssum >>> 15);
         end
      end else if (lin_ff < LW'(0)) begin
         level_in = '0;
      end else if (lin_ff > LW'(LEVEL_MAX)) begin
         level_in = 8'(LEVEL_MAX);
      end else begin
         level_in = 8'(lin_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         level_ff <= level_in;
      end
   end

   // Scale both alphas by the level, pass through for type none
   logic [15:0]     ap_scl;
   logic [15:0]     as_scl;
   rsp_payload_type out_d;
   carry_type       c_last;

   assign c_last = carry_ff[NST-1];
   assign ap_scl = 16'(c_last.ap) * 16'(level_ff) + 16'd128;
   assign as_scl = 16'(c_last.as) * 16'(level_ff) + 16'd128;

   always_comb begin
      if (type_ff == FLICK_NONE) begin
         out_d.alpha_primary_out   = c_last.ap;
         out_d.alpha_secondary_out = c_last.as;
      end else begin
         out_d.alpha_primary_out   = ap_scl[15:8];
         out_d.alpha_secondary_out = as_scl[15:8];
      end
   end

   afm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[NST-1] & en),
      .in_data   (out_d),
      .skid_full (skid_full),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
